### hw/rtl/mnpt_pkg.sv
`timescale 1ns / 1ps

package mnpt_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned KEY_W          = 7;
  localparam int unsigned FREQ_W         = 22;
  localparam int unsigned NUM_KEYS       = 1 << KEY_W;
  localparam int unsigned FREQ_FRAC_BITS = 8;
  localparam int unsigned ROM_UNITS      = 100000;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Note status bytes: top three bits 100, bit 4 picks note-on
  localparam logic [2:0] NOTE_STATUS_TOP = 3'b100;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_SET     = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    logic             done;
    op_e              op;
    logic [KEY_W-1:0] key;
  } mnpt_evt_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } mnpt_qstat_t;

  typedef logic [31:0]       units_tab_t [NUM_KEYS];
  typedef logic [FREQ_W-1:0] freq_tab_t  [NUM_KEYS];

  // Key frequencies in units of 1e-5 Hz
  localparam units_tab_t PITCH_UNITS = '{
    32'd817580,     32'd866196,     32'd917702,     32'd972272,     32'd1030090,
    32'd1091340,    32'd1156230,    32'd1224990,    32'd1297830,    32'd1375000,
    32'd1456760,    32'd1543390,    32'd1635160,    32'd1732390,    32'd1835400,
    32'd1944540,    32'd2060170,    32'd2182680,    32'd2312470,    32'd2449970,
    32'd2595650,    32'd2750000,    32'd2913520,    32'd3086770,    32'd3270320,
    32'd3464780,    32'd3670810,    32'd3889090,    32'd4120340,    32'd4365350,
    32'd4624930,    32'd4899940,    32'd5191310,    32'd5500000,    32'd5827050,
    32'd6173540,    32'd6540640,    32'd6929570,    32'd7341620,    32'd7778170,
    32'd8240690,    32'd8730710,    32'd9249860,    32'd9799890,    32'd10382600,
    32'd11000000,   32'd11654100,   32'd12347100,   32'd13081300,   32'd13859100,
    32'd14683200,   32'd15556300,   32'd16481400,   32'd17461400,   32'd18499700,
    32'd19599800,   32'd20765200,   32'd22000000,   32'd23308200,   32'd24694200,
    32'd26162600,   32'd27718300,   32'd29366500,   32'd31112700,   32'd32962800,
    32'd34922800,   32'd36999400,   32'd39199500,   32'd41530500,   32'd44000000,
    32'd46616400,   32'd49388300,   32'd52325100,   32'd55436500,   32'd58733000,
    32'd62225400,   32'd65925500,   32'd69845600,   32'd73998900,   32'd78399100,
    32'd83060900,   32'd88000000,   32'd93232800,   32'd98776700,   32'd104650000,
    32'd110873000,  32'd117466000,  32'd124451000,  32'd131851000,  32'd139691000,
    32'd147998000,  32'd156798000,  32'd166122000,  32'd176000000,  32'd186466000,
    32'd197553000,  32'd209300000,  32'd221746000,  32'd234932000,  32'd248902000,
    32'd263702000,  32'd279383000,  32'd295996000,  32'd313596000,  32'd332244000,
    32'd352000000,  32'd372931000,  32'd395107000,  32'd418601000,  32'd443492000,
    32'd469864000,  32'd497803000,  32'd527404000,  32'd558765000,  32'd591991000,
    32'd627193000,  32'd664488000,  32'd704000000,  32'd745862000,  32'd790213000,
    32'd837202000,  32'd886984000,  32'd939727000,  32'd995606000,  32'd1054810000,
    32'd1117530000, 32'd1183980000, 32'd1254390000
  };

  // Scale to fixed point, round half up, saturate; evaluated at elaboration only
  function automatic freq_tab_t build_freq_tab();
    freq_tab_t   tab;
    logic [63:0] scaled;
    logic [63:0] quot;
    for (int i = 0; i < NUM_KEYS; i++) begin
      scaled = ({32'd0, PITCH_UNITS[i]} << FREQ_FRAC_BITS) + 64'(ROM_UNITS / 2);
      quot   = scaled / ROM_UNITS;
      tab[i] = (quot > 64'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
    end
    return tab;
  endfunction

  localparam freq_tab_t FREQ_TAB = build_freq_tab();

endpackage

### hw/rtl/mnpt_if.sv
`timescale 1ns / 1ps

interface mnpt_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mnpt_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mnpt_note_if;
  logic                        valid;
  logic                        ready;
  logic                        message_done;
  logic                        note_active;
  logic [mnpt_pkg::KEY_W-1:0]  key_number;
  logic [mnpt_pkg::FREQ_W-1:0] note_frequency;

  modport source (output valid, output message_done, output note_active,
                  output key_number, output note_frequency, input ready);
  modport sink   (input valid, input message_done, input note_active,
                  input key_number, input note_frequency, output ready);
endinterface

### hw/rtl/mnpt_parser.sv
`timescale 1ns / 1ps

module mnpt_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mnpt_byte_if.sink             byte_i,
  input  mnpt_pkg::mnpt_qstat_t qstat_i,
  output logic                  push_o,
  output mnpt_pkg::mnpt_evt_t   evt_o
);

  localparam logic [1:0] POS_IDLE = 2'd0;
  localparam logic [1:0] POS_KEY  = 2'd1;
  localparam logic [1:0] POS_VEL  = 2'd2;

  logic [1:0]                 pos_q, pos_d;
  logic                       pend_on_q, pend_on_d;
  logic [mnpt_pkg::KEY_W-1:0] pend_key_q, pend_key_d;
  logic [1:0]                 pos_eff;
  logic [mnpt_pkg::BYTE_W-1:0] b;

  assign byte_i.ready = !qstat_i.full;
  assign push_o       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.rx_byte;

  always_comb begin
    pos_eff    = pos_q;
    pos_d      = pos_q;
    pend_on_d  = pend_on_q;
    pend_key_d = pend_key_q;
    evt_o.done = 1'b0;
    evt_o.op   = mnpt_pkg::OP_NONE;
    evt_o.key  = pend_key_q;

    // A status byte mid-message drops it and is parsed afresh
    if ((pos_q == POS_KEY || pos_q == POS_VEL) && b[mnpt_pkg::BYTE_W-1]) begin
      pos_eff = POS_IDLE;
    end

    unique case (pos_eff)
      POS_KEY: begin
        pend_key_d = b[mnpt_pkg::KEY_W-1:0];
        pos_d      = POS_VEL;
      end
      POS_VEL: begin
        evt_o.done = 1'b1;
        if (pend_on_q && (b[mnpt_pkg::KEY_W-1:0] != '0)) begin
          evt_o.op = mnpt_pkg::OP_SET;
        end else begin
          evt_o.op = mnpt_pkg::OP_RELEASE;
        end
        pos_d = POS_IDLE;
      end
      default: begin
        pos_d = POS_IDLE;
        if (b[7:5] == mnpt_pkg::NOTE_STATUS_TOP) begin
          pend_on_d = b[4];
          pos_d     = POS_KEY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_IDLE;
      pend_on_q  <= 1'b0;
      pend_key_q <= '0;
    end else if (push_o) begin
      pos_q      <= pos_d;
      pend_on_q  <= pend_on_d;
      pend_key_q <= pend_key_d;
    end
  end

endmodule

### hw/rtl/mnpt_queue.sv
`timescale 1ns / 1ps

module mnpt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mnpt_pkg::mnpt_evt_t   evt_i,
  input  logic                  pop_i,
  output mnpt_pkg::mnpt_evt_t   evt_o,
  output mnpt_pkg::mnpt_qstat_t qstat_o
);

  mnpt_pkg::mnpt_evt_t                 mem_q [mnpt_pkg::QUEUE_DEPTH];
  logic [mnpt_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [mnpt_pkg::QCNT_W-1:0]         count_q, count_d;

  assign count_d = count_q + mnpt_pkg::QCNT_W'(push_i) - mnpt_pkg::QCNT_W'(pop_i);

  assign evt_o         = mem_q[rd_ptr_q];
  assign qstat_o.count = count_q;
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == mnpt_pkg::QCNT_W'(mnpt_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

endmodule

### hw/rtl/mnpt_tracker.sv
`timescale 1ns / 1ps

module mnpt_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mnpt_pkg::mnpt_evt_t   evt_i,
  input  mnpt_pkg::mnpt_qstat_t qstat_i,
  output logic                  pop_o,
  mnpt_note_if.source           note_o
);

  logic                        held_valid_q, held_valid_d;
  logic [mnpt_pkg::KEY_W-1:0]  held_key_q, held_key_d;
  logic                        out_valid_q;
  logic                        done_q;
  logic                        active_q;
  logic [mnpt_pkg::KEY_W-1:0]  key_q;
  logic [mnpt_pkg::FREQ_W-1:0] freq_q;

  // Advance whenever the queue holds an event and the output register is free or being taken
  assign pop_o = !qstat_i.empty && (!out_valid_q || note_o.ready);

  always_comb begin
    held_valid_d = held_valid_q;
    held_key_d   = held_key_q;
    unique case (evt_i.op)
      mnpt_pkg::OP_SET: begin
        held_valid_d = 1'b1;
        held_key_d   = evt_i.key;
      end
      mnpt_pkg::OP_RELEASE: begin
        // Release only the key that is held
        if (held_valid_q && (held_key_q == evt_i.key)) begin
          held_valid_d = 1'b0;
          held_key_d   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_key_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        held_valid_q <= held_valid_d;
        held_key_q   <= held_key_d;
        out_valid_q  <= 1'b1;
      end else if (note_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      done_q   <= evt_i.done;
      active_q <= held_valid_d;
      key_q    <= held_valid_d ? held_key_d : '0;
      freq_q   <= held_valid_d ? mnpt_pkg::FREQ_TAB[held_key_d] : '0;
    end
  end

  assign note_o.valid          = out_valid_q;
  assign note_o.message_done   = done_q;
  assign note_o.note_active    = active_q;
  assign note_o.key_number     = key_q;
  assign note_o.note_frequency = freq_q;

endmodule

### hw/rtl/midi_note_parser_tracker.sv
`timescale 1ns / 1ps

// MIDI note-on/note-off parser with a monophonic note tracker. Takes one MIDI
// byte per beat on byte_i and returns one beat on note_o for every byte: the
// message-done flag, whether a key is held, the held key and its frequency in
// Hz with FREQ_FRAC_BITS fraction bits (zero when nothing is held). Bytes are
// taken at one per cycle for as long as the output side keeps up; a result
// passes through the event queue and then the output register of the
// tracker. A two-entry event queue between the parser and the tracker lets
// the input keep flowing while the output stalls, until the queue is full.
// Status bytes other than note-on and note-off, and stray data bytes, still
// yield a beat that repeats the current note.
module midi_note_parser_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  mnpt_byte_if.sink   byte_i,
  mnpt_note_if.source note_o
);

  mnpt_pkg::mnpt_evt_t   push_evt;
  mnpt_pkg::mnpt_evt_t   pop_evt;
  mnpt_pkg::mnpt_qstat_t qstat;
  logic                  push;
  logic                  pop;

  mnpt_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .qstat_i (qstat),
    .push_o  (push),
    .evt_o   (push_evt)
  );

  mnpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (push_evt),
    .pop_i   (pop),
    .evt_o   (pop_evt),
    .qstat_o (qstat)
  );

  mnpt_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (pop_evt),
    .qstat_i (qstat),
    .pop_o   (pop),
    .note_o  (note_o)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= mnpt_pkg::QCNT_W'(mnpt_pkg::QUEUE_DEPTH))
    else $error("event queue count beyond depth");

  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
    else $error("event queue count did not advance on push");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("tracker took an event from an empty queue");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_o.valid |-> (note_o.note_active == (note_o.note_frequency != '0)) &&
                     (note_o.note_active || (note_o.key_number == '0)))
    else $error("note fields disagree with note_active");
`endif

endmodule
